@@ rtl/sha256_stream_hasher_macros.svh @@
// Assertion macros used by the hasher core
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH

// Property holds at every edge outside reset
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition implies a consequent on the next edge
`define SHA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

@@ rtl/sha_pkg.sv @@
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } sha_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } sha_result_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[i];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

@@ rtl/sha_stream_if.sv @@
interface sha_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/sha_front.sv @@
// Front end: drop idle beats and queue the rest for the core
module sha_front
  import sha_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  sha_stream_if.sink in_ch,
  output logic       q_valid,
  output sha_item_t  q_item,
  input  logic       q_take
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sha_item_t        mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [AW:0]      count;
  logic             push;
  logic             pop;

  assign in_ch.ready = (count != (AW+1)'(DEPTH));
  assign push = in_ch.valid && in_ch.ready &&
                (in_ch.payload.has_byte || in_ch.payload.end_of_message);
  assign q_valid = (count != '0);
  assign pop = q_valid && q_take;
  assign q_item = mem[rd_ptr];

  // Store useful beats
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_ch.payload;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

@@ rtl/sha_core.sv @@
`include "sha256_stream_hasher_macros.svh"
// Back end: buffer bytes, pad, run the rounds, emit the digest
module sha_core
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  sha_item_t   q_item,
  output logic        q_take,
  sha_stream_if.source out_ch
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PAD   = 6'b000010,
    S_LOAD  = 6'b000100,
    S_ROUND = 6'b001000,
    S_ADD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  state_t       state;
  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [31:0]  buf_mem [16];
  logic [5:0]   fill;
  logic [63:0]  message_bits;
  logic [63:0]  total;
  logic         padding;
  logic         extra_block;
  logic         finish;
  logic [5:0]   rnd;
  logic [3:0]   ld;
  logic [2:0]   emit_idx;
  logic [7:0]   pad_byte;
  logic [7:0]   wr_byte;
  logic         wr_en;
  logic [31:0]  ld_word;
  logic [31:0]  w_next;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  s0;
  logic [31:0]  s1;

  assign q_take = (state == S_IDLE) && q_valid;

  // Padding byte for the current fill position; the length goes in the last block only
  always_comb begin
    if (!padding) begin
      pad_byte = PadByte;
    end else if (fill >= 6'd56 && !extra_block) begin
      pad_byte = total[{3'd7 - fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign wr_en = (state == S_PAD) || (q_take && q_item.has_byte);
  assign wr_byte = (state == S_PAD) ? pad_byte : q_item.data_byte;

  // Message schedule and round function
  assign s0 = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
  assign s1 = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
  assign w_next = w[0] + s0 + w[9] + s1;
  assign t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
              ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + w[0];
  assign t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
              ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  // Block buffer as big-endian words, one byte lane per beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  // Registered word read for schedule load
  always_ff @(posedge clk) begin
    ld_word <= buf_mem[ld];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fill         <= '0;
      message_bits <= '0;
      padding      <= 1'b0;
      extra_block  <= 1'b0;
      finish       <= 1'b0;
      rnd          <= '0;
      ld           <= '0;
      emit_idx     <= '0;
      out_ch.valid <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        h[i] <= init_h(3'(i));
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (q_take) begin
            padding <= 1'b0;
            if (q_item.has_byte) begin
              message_bits <= message_bits + 64'd8;
              fill <= fill + 6'd1;
            end
            if (q_item.end_of_message) begin
              total  <= q_item.has_byte ? message_bits + 64'd8 : message_bits;
              finish <= 1'b1;
            end else begin
              finish <= 1'b0;
            end
            if (q_item.has_byte && fill == 6'd63) begin
              state <= S_LOAD;
              ld    <= '0;
            end else if (q_item.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Marker past byte 55 pushes the length into one more block
          if (!padding) begin
            extra_block <= (fill >= 6'd56);
          end
          padding <= 1'b1;
          fill    <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= S_LOAD;
            ld    <= '0;
          end
        end
        S_LOAD: begin
          // ld_word holds the word that ld addressed in the previous cycle
          ld <= ld + 4'd1;
          if (ld != 4'd0) begin
            w[ld - 4'd1] <= ld_word;
          end
          if (ld == 4'd0) begin
            for (int i = 0; i < 8; i++) begin
              v[i] <= h[i];
            end
          end
          if (ld == 4'd15) begin
            state <= S_ROUND;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          // Slide the schedule window; the last loaded word joins on the first round
          for (int i = 0; i < 14; i++) begin
            w[i] <= w[i + 1];
          end
          w[14] <= (rnd == 6'd0) ? ld_word : w[15];
          w[15] <= w_next;
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          if (finish && padding && !extra_block) begin
            state    <= S_EMIT;
            emit_idx <= '0;
            out_ch.valid <= 1'b1;
          end else if (finish && padding) begin
            extra_block <= 1'b0;
            state       <= S_PAD;
          end else if (finish) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              out_ch.valid <= 1'b0;
              state        <= S_IDLE;
              fill         <= '0;
              message_bits <= '0;
              finish       <= 1'b0;
              padding      <= 1'b0;
              for (int i = 0; i < 8; i++) begin
                h[i] <= init_h(3'(i));
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.payload.digest_word = h[emit_idx];
  assign out_ch.payload.word_index  = emit_idx;
  assign out_ch.payload.last_word   = (emit_idx == 3'd7);

  `SHA_ASSERT(a_take_idle, !q_take || state == S_IDLE, "item taken while busy")
  `SHA_ASSERT(a_valid_emit, out_ch.valid == (state == S_EMIT), "output valid outside emit")
  `SHA_ASSERT_NEXT(a_last_done, out_ch.valid && out_ch.ready && out_ch.payload.last_word,
                   state == S_IDLE && fill == 6'd0, "no reinit after digest")
endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher, one byte per input beat; beats wait in the front queue.
// A byte beat that does not fill a block leaves the core idle; a full block first runs
// the load, round and add states, and the core takes no beat until they are done.
// An end beat pads at one byte a cycle (up to 64 per block), compresses once or twice,
// then presents eight digest beats, one per cycle while ready is high.
// Synchronous reset restores the initial hash values and empties the front queue.
module sha256_stream_hasher
  import sha_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch
);
  logic      q_valid;
  logic      q_take;
  sha_item_t q_item;

  sha_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_valid(q_valid), .q_item(q_item), .q_take(q_take)
  );

  sha_core u_core (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item),
    .q_take(q_take), .out_ch(out_ch)
  );
endmodule
